// ===== sv/lpcf_pkg.sv =====
// ----------------------------------------------------------------------------
// lpcf_pkg: shared types and constants of the lane point cloud filter
// Register indexes, fixed field widths and the item structs.
// ----------------------------------------------------------------------------
package lpcf_pkg;

  localparam int IMAGE_WIDTH_DEF  = 640;
  localparam int IMAGE_HEIGHT_DEF = 480;
  localparam int DECIMATION_DEF   = 5;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_H     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_COS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_SIN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_LIM   = 3'd7;

  localparam logic signed [31:0] FORWARD_MIN = 32'sd9831;
  localparam logic signed [31:0] FORWARD_MAX = 32'sd65536;

  localparam logic        CMD_MASK  = 1'b0;
  localparam logic        CMD_POINT = 1'b1;

  // Queue entry from front to back: one used point.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } lpcf_point_t;

  // Result item.
  typedef struct packed {
    logic signed [31:0] base_z;
    logic signed [31:0] base_y;
    logic signed [31:0] base_x;
    logic signed [31:0] cam_z;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_x;
    logic               in_lane;
    logic               on_mask;
  } lpcf_result_t;

  // Configuration register set.
  typedef struct packed {
    logic [30:0]        focal_x;
    logic [30:0]        focal_y;
    logic [30:0]        center_x;
    logic [30:0]        center_y;
    logic signed [31:0] camera_height;
    logic signed [17:0] pitch_cosine;
    logic signed [17:0] pitch_sine;
    logic [30:0]        lateral_limit;
  } lpcf_cfg_t;

endpackage

// ===== sv/lpcf_ram.sv =====
// ----------------------------------------------------------------------------
// lpcf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lpcf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/lpcf_front.sv =====
// ----------------------------------------------------------------------------
// lpcf_front: input classifier
// Splits mask writes from points, decimates points, queues used points.
// ----------------------------------------------------------------------------
module lpcf_front
  import lpcf_pkg::*;
#(
  parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF,
  parameter int DECIMATION   = DECIMATION_DEF,
  parameter int PIX_W        = $clog2(IMAGE_WIDTH * IMAGE_HEIGHT)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cmd,
  input  logic [18:0]       mask_index,
  input  logic              mask_bit,
  input  lpcf_point_t       pt,
  input  logic              first_point,
  // back part still holds a point
  input  logic              back_busy,
  // mask write port, applied in the cycle of acceptance
  output logic              mask_we,
  output logic [PIX_W-1:0]  mask_waddr,
  output logic              mask_wdata,
  // queue toward the back part
  output logic              q_valid,
  input  logic              q_ready,
  output lpcf_point_t       q_data
);

  localparam int PH_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
  localparam int PIXELS = IMAGE_WIDTH * IMAGE_HEIGHT;

  logic [PH_W-1:0] point_phase;
  logic [PH_W-1:0] phase_cur;
  logic [PH_W-1:0] phase_next;

  // two-entry queue
  lpcf_point_t qmem [2];
  logic        wptr, rptr;
  logic [1:0]  count;

  logic acc;
  logic push;
  logic pop;
  logic mask_hold;

  // a mask write waits until the queue is empty and the back part is idle
  assign mask_hold = (cmd == CMD_MASK) && ((count != 2'd0) || back_busy);
  assign in_ready  = (count != 2'd2) && !mask_hold;
  assign acc       = in_valid && in_ready;

  assign phase_cur  = first_point ? '0 : point_phase;
  assign phase_next = (phase_cur == PH_W'(DECIMATION - 1)) ? '0 : phase_cur + 1'b1;

  assign push = acc && (cmd == CMD_POINT) && (phase_cur == '0) && (pt.z != 0);
  assign pop  = q_valid && q_ready;

  assign mask_we    = acc && (cmd == CMD_MASK) && ({1'b0, mask_index} < 20'(PIXELS));
  assign mask_waddr = mask_index[PIX_W-1:0];
  assign mask_wdata = mask_bit;

  assign q_valid = (count != 2'd0);
  assign q_data  = qmem[rptr];

  // decimation phase
  always_ff @(posedge clk) begin
    if (rst) begin
      point_phase <= '0;
    end else if (acc && (cmd == CMD_POINT)) begin
      point_phase <= phase_next;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wptr] <= pt;
    end
  end

endmodule

// ===== sv/lpcf_divider.sv =====
// ----------------------------------------------------------------------------
// lpcf_divider: unsigned restoring divider, one quotient bit per cycle
// Divides a 64-bit magnitude by a 64-bit magnitude.
// ----------------------------------------------------------------------------
module lpcf_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quot
);

  logic [63:0] rem;
  logic [63:0] d;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] trial;

  assign trial = {rem[63:0], quot[63]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
        rem  <= '0;
        quot <= num;
        d    <= den;
      end else if (busy) begin
        // shift in one numerator bit, subtract if it fits
        if (!trial[64]) begin
          rem  <= trial[63:0];
          quot <= {quot[62:0], 1'b1};
        end else begin
          rem  <= {rem[62:0], quot[63]};
          quot <= {quot[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/lpcf_back.sv =====
// ----------------------------------------------------------------------------
// lpcf_back: projection and base frame sequencer
// Projects a point; if on the image, reads mask, rotates and filters it.
// ----------------------------------------------------------------------------
module lpcf_back
  import lpcf_pkg::*;
#(
  parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF,
  parameter int PIX_W        = $clog2(IMAGE_WIDTH * IMAGE_HEIGHT)
) (
  input  logic              clk,
  input  logic              rst,
  input  lpcf_cfg_t         cfg,
  input  logic              q_valid,
  output logic              q_ready,
  input  lpcf_point_t       q_data,
  output logic              busy,
  output logic              mask_re,
  output logic [PIX_W-1:0]  mask_raddr,
  input  logic              mask_rdata,
  output logic              res_valid,
  input  logic              res_ready,
  output lpcf_result_t      res
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_MULA  = 11'b00000000010,
    S_SUMA  = 11'b00000000100,
    S_DIVU  = 11'b00000001000,
    S_MULB  = 11'b00000010000,
    S_SUMB  = 11'b00000100000,
    S_DIVV  = 11'b00001000000,
    S_ADDR  = 11'b00010000000,
    S_READ  = 11'b00100000000,
    S_DONE  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state, state_next;

  lpcf_point_t p;
  logic signed [63:0] prod_a, prod_b;
  logic signed [63:0] num;
  logic signed [63:0] den;
  logic               neg;
  logic signed [63:0] u, v;
  logic signed [63:0] rx, rz;
  logic [31:0]        pix_row;

  // divider
  logic        div_start, div_done;
  logic        div_go;
  logic [63:0] div_num, div_den, div_q;
  logic [63:0] num_mag, den_mag;

  lpcf_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  assign num_mag = num[63] ? 64'(-num) : 64'(num);
  assign den_mag = den[63] ? 64'(-den) : 64'(den);
  assign div_num = num_mag + (den_mag >> 1);
  assign div_den = den_mag;
  assign div_start = div_go;

  // start the division in the first divide cycle, once num is registered
  always_ff @(posedge clk) begin
    if (rst) begin
      div_go <= 1'b0;
    end else begin
      div_go <= (state == S_SUMA) || (state == S_SUMB);
    end
  end

  function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
    logic signed [31:0] r;
    if (a > 64'sd2147483647)       r = 32'sh7FFFFFFF;
    else if (a < -64'sd2147483648) r = 32'sh80000000;
    else                           r = a[31:0];
    return r;
  endfunction

  function automatic logic signed [63:0] rnd16(input logic signed [63:0] a);
    logic [63:0] m;
    logic [63:0] q;
    m = a[63] ? 64'(-a) : 64'(a);
    q = (m + 64'd32768) >> 16;
    return a[63] ? 64'(-q) : 64'(q);
  endfunction

  logic signed [63:0] bx_full, bz_full;
  logic signed [31:0] bx, by, bz;
  logic [31:0]        aby;
  logic               in_img;

  assign q_ready = (state == S_IDLE);
  assign busy    = (state != S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (q_valid) state_next = S_MULA;
      S_MULA: state_next = S_SUMA;
      S_SUMA: state_next = S_DIVU;
      S_DIVU: if (div_done) state_next = S_MULB;
      S_MULB: state_next = S_SUMB;
      S_SUMB: state_next = S_DIVV;
      S_DIVV: if (div_done) state_next = S_ADDR;
      S_ADDR: state_next = in_img ? S_READ : S_IDLE;
      S_READ: state_next = S_DONE;
      S_DONE: state_next = S_OUT;
      S_OUT:  if (res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign in_img = !u[63] && (u < 64'(IMAGE_WIDTH)) && !v[63] && (v < 64'(IMAGE_HEIGHT));

  assign mask_re    = (state == S_READ);
  assign mask_raddr = PIX_W'(pix_row + 32'(u[15:0]));

  // datapath: four products per multiply step, registered
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        p <= q_data;
      end
      S_MULA: begin
        prod_a <= $signed({1'b0, cfg.focal_x}) * p.x;
        prod_b <= $signed({1'b0, cfg.center_x}) * p.z;
        den    <= 64'(p.z) <<< 16;
        rx     <= cfg.pitch_cosine * p.z;
        rz     <= cfg.pitch_sine * p.y;
      end
      S_SUMA: begin
        num <= prod_a + prod_b;
        neg <= (prod_a + prod_b < 0) != den[63];
        bx_full <= rx - rz;
      end
      S_DIVU: begin
        if (div_done) u <= neg ? 64'(-div_q) : 64'(div_q);
      end
      S_MULB: begin
        prod_a <= $signed({1'b0, cfg.focal_y}) * p.y;
        prod_b <= $signed({1'b0, cfg.center_y}) * p.z;
        rx     <= -(cfg.pitch_sine * p.z);
        rz     <= cfg.pitch_cosine * p.y;
      end
      S_SUMB: begin
        num <= prod_a + prod_b;
        neg <= (prod_a + prod_b < 0) != den[63];
        bz_full <= rx - rz;
      end
      S_DIVV: begin
        if (div_done) v <= neg ? 64'(-div_q) : 64'(div_q);
      end
      S_ADDR: begin
        pix_row <= 32'(v[15:0]) * 32'(IMAGE_WIDTH);
        bx <= sat32(rnd16(bx_full));
        by <= sat32(-64'(p.x));
        bz <= sat32(rnd16(bz_full) + 64'(cfg.camera_height));
      end
      S_DONE: begin
        res.cam_x   <= p.x;
        res.cam_y   <= p.y;
        res.cam_z   <= p.z;
        res.base_x  <= bx;
        res.base_y  <= by;
        res.base_z  <= bz;
        res.on_mask <= (cfg.focal_x != '0) && mask_rdata;
        res.in_lane <= (cfg.focal_x != '0) && mask_rdata && (bx >= FORWARD_MIN) &&
                       (bx <= FORWARD_MAX) && (aby <= {1'b0, cfg.lateral_limit});
      end
      default: ;
    endcase
  end

  assign aby = by[31] ? 32'(-by) : 32'(by);

  assign res_valid = (state == S_OUT);

endmodule

// ===== sv/lane_point_cloud_filter.sv =====
// ----------------------------------------------------------------------------
// lane_point_cloud_filter: lane point filter for a depth camera stream
//
// channel | dir | handshake               | payload
// s_axis  | in  | s_axis_tvalid/tready    | tdata, tuser={first_point,cmd}
// m_axis  | out | m_axis_tvalid/tready    | tdata, tuser={in_lane,on_mask}
// cfg     | in  | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
// Unused points are taken at one item per cycle while the queue has room.
// A used point holds the back sequencer until its result is taken, chiefly in
// the two bit-serial 64-bit divisions for the column and the row; a point
// whose pixel is off the image frees it without a result.
// A two-entry queue lets the front keep accepting points while the back works;
// a mask write waits until no point is queued or in the back.
// rst is synchronous; registers return to their reset values, the mask is
// undefined until written.
// ----------------------------------------------------------------------------
module lane_point_cloud_filter
  import lpcf_pkg::*;
#(
  parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF,
  parameter int DECIMATION   = DECIMATION_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mask_index[18:0], mask_bit[19], pt_x[51:20], pt_y[83:52], pt_z[115:84]
  input  logic [119:0] s_axis_tdata,
  // cmd[0], first_point[1]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // cam_x, cam_y, cam_z, base_x, base_y, base_z, 32 bits each
  output logic [191:0] m_axis_tdata,
  // on_mask[0], in_lane[1]
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int PIXELS = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int PIX_W  = $clog2(PIXELS);

  lpcf_cfg_t    cfg;
  lpcf_point_t  pt;
  lpcf_point_t  q_data;
  lpcf_result_t res;
  logic q_valid, q_ready;
  logic back_busy;
  logic mask_we, mask_wdata, mask_re, mask_rdata;
  logic [PIX_W-1:0] mask_waddr, mask_raddr;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_x       <= '0;
      cfg.focal_y       <= '0;
      cfg.center_x      <= '0;
      cfg.center_y      <= '0;
      cfg.camera_height <= 32'sd19661;
      cfg.pitch_cosine  <= 18'sd59396;
      cfg.pitch_sine    <= 18'sd27697;
      cfg.lateral_limit <= 31'd18022;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FOCAL_X:   cfg.focal_x       <= cfg_data[30:0];
        REG_FOCAL_Y:   cfg.focal_y       <= cfg_data[30:0];
        REG_CENTER_X:  cfg.center_x      <= cfg_data[30:0];
        REG_CENTER_Y:  cfg.center_y      <= cfg_data[30:0];
        REG_CAM_H:     cfg.camera_height <= cfg_data;
        REG_PITCH_COS: cfg.pitch_cosine  <= cfg_data[17:0];
        REG_PITCH_SIN: cfg.pitch_sine    <= cfg_data[17:0];
        REG_LAT_LIM:   cfg.lateral_limit <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign pt.x = s_axis_tdata[51:20];
  assign pt.y = s_axis_tdata[83:52];
  assign pt.z = s_axis_tdata[115:84];

  lpcf_front #(
    .IMAGE_WIDTH (IMAGE_WIDTH),
    .IMAGE_HEIGHT(IMAGE_HEIGHT),
    .DECIMATION  (DECIMATION),
    .PIX_W       (PIX_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .cmd        (s_axis_tuser[0]),
    .mask_index (s_axis_tdata[18:0]),
    .mask_bit   (s_axis_tdata[19]),
    .pt         (pt),
    .first_point(s_axis_tuser[1]),
    .back_busy  (back_busy),
    .mask_we    (mask_we),
    .mask_waddr (mask_waddr),
    .mask_wdata (mask_wdata),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_data     (q_data)
  );

  lpcf_ram #(
    .WIDTH(1),
    .DEPTH(PIXELS)
  ) u_mask (
    .clk  (clk),
    .we   (mask_we),
    .waddr(mask_waddr),
    .wdata(mask_wdata),
    .re   (mask_re),
    .raddr(mask_raddr),
    .rdata(mask_rdata)
  );

  lpcf_back #(
    .IMAGE_WIDTH (IMAGE_WIDTH),
    .IMAGE_HEIGHT(IMAGE_HEIGHT),
    .PIX_W       (PIX_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .busy      (back_busy),
    .mask_re   (mask_re),
    .mask_raddr(mask_raddr),
    .mask_rdata(mask_rdata),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {res.base_z, res.base_y, res.base_x, res.cam_z, res.cam_y, res.cam_x};
  assign m_axis_tuser = {res.in_lane, res.on_mask};

`ifndef ASSERT_OFF
  // in_lane only on a mask hit
  a_lane_needs_mask: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (!m_axis_tuser[1] || m_axis_tuser[0]))
    else $error("in_lane without on_mask");

  // uncalibrated results carry no flags
  a_uncal_flags: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && cfg.focal_x == '0) |-> (m_axis_tuser == 2'b00))
    else $error("flag set while uncalibrated");

  // back part never pops the queue while a result waits
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !q_ready)
    else $error("queue popped during output");
`endif

endmodule
